// ===== sv/cftr_pkg.sv =====
// ----------------------------------------------------------------------------
// cftr_pkg
// Shared types for the CAN frame change tracker: request and response
// payloads and the transaction record that travels along the slot chain.
// ----------------------------------------------------------------------------
package cftr_pkg;

   localparam int unsigned IFACE_BITS = 2;
   localparam int unsigned ID_BITS    = 29;
   localparam int unsigned KEY_BITS   = IFACE_BITS + ID_BITS;
   localparam int unsigned LEN_BITS   = 4;
   localparam int unsigned DATA_BYTES = 8;
   localparam int unsigned DATA_BITS  = 8 * DATA_BYTES;
   localparam int unsigned TIME_BITS  = 32;
   localparam int unsigned SEQ_BITS   = 32;

   typedef struct packed {
      logic [IFACE_BITS-1:0] interface_number;
      logic [ID_BITS-1:0]    frame_id;
      logic [LEN_BITS-1:0]   byte_count;
      logic [DATA_BITS-1:0]  payload;
      logic [TIME_BITS-1:0]  arrival_time;
   } req_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0]   sequence_number;
      logic                  first_seen;
      logic [DATA_BYTES-1:0] changed_bytes;
      logic                  notify;
      logic [TIME_BITS-1:0]  mean_interval;
      logic                  dropped_full;
   } rsp_type;

   // Transaction record handed from cell to cell.
   typedef struct packed {
      logic                  valid;
      logic                  done;      // a cell has matched or claimed it
      logic                  first;
      logic [DATA_BYTES-1:0] mask;
      logic [TIME_BITS-1:0]  average;
      logic [SEQ_BITS-1:0]   seq;
      logic [KEY_BITS-1:0]   key;
      logic [LEN_BITS-1:0]   len;
      logic [DATA_BITS-1:0]  payload;
      logic [TIME_BITS-1:0]  now;
   } flow_type;

endpackage

// ===== sv/cftr_cell.sv =====
// ----------------------------------------------------------------------------
// cftr_cell
// One table slot of the tracker. Checks the passing transaction against its
// own key, updates or claims the slot, and registers the transaction for
// the next cell.
// ----------------------------------------------------------------------------
module cftr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  cftr_pkg::flow_type flow_i,
   output cftr_pkg::flow_type flow_o
);

   logic                                slot_valid_ff, slot_valid_in;
   logic [cftr_pkg::KEY_BITS-1:0]       slot_key_ff, slot_key_in;
   logic [cftr_pkg::LEN_BITS-1:0]       slot_length_ff, slot_length_in;
   logic [cftr_pkg::DATA_BITS-1:0]      slot_payload_ff, slot_payload_in;
   logic [cftr_pkg::TIME_BITS-1:0]      slot_last_time_ff, slot_last_time_in;
   logic [cftr_pkg::TIME_BITS-1:0]      slot_average_ff, slot_average_in;
   cftr_pkg::flow_type                  flow_ff, flow_in;

   logic                                pending;
   logic                                hit;
   logic                                len_ne;
   logic [cftr_pkg::DATA_BYTES-1:0]     active;
   logic [cftr_pkg::DATA_BYTES-1:0]     byte_ne;
   logic [cftr_pkg::DATA_BYTES-1:0]     mask;
   logic                                same;
   logic [cftr_pkg::TIME_BITS-1:0]      avg_sum;

   // Byte compare and change mask
   always_comb begin
      len_ne = (flow_i.len != slot_length_ff);
      for (int i = 0; i < cftr_pkg::DATA_BYTES; i++) begin
         active[i]  = (cftr_pkg::LEN_BITS'(i) < flow_i.len);
         byte_ne[i] = (flow_i.payload[8*i +: 8] != slot_payload_ff[8*i +: 8]);
         mask[i]    = active[i] & (len_ne | byte_ne[i]);
      end
      same    = !len_ne && ((active & byte_ne) == '0);
      avg_sum = flow_i.now - slot_last_time_ff + slot_average_ff;
   end

   assign pending = flow_i.valid && !flow_i.done;
   assign hit     = pending && slot_valid_ff && (slot_key_ff == flow_i.key);

   // Slot update and transaction hand-off
   always_comb begin
      slot_valid_in     = slot_valid_ff;
      slot_key_in       = slot_key_ff;
      slot_length_in    = slot_length_ff;
      slot_payload_in   = slot_payload_ff;
      slot_last_time_in = slot_last_time_ff;
      slot_average_in   = slot_average_ff;
      flow_in           = flow_i;
      if (hit) begin
         flow_in.done      = 1'b1;
         flow_in.mask      = mask;
         flow_in.average   = avg_sum >> 1;
         slot_last_time_in = flow_i.now;
         slot_average_in   = avg_sum >> 1;
         if (!same) begin
            slot_length_in  = flow_i.len;
            slot_payload_in = flow_i.payload;
         end
      end else if (pending && !slot_valid_ff) begin
         // Slots fill in order, so the first free one ends the search.
         flow_in.done      = 1'b1;
         flow_in.first     = 1'b1;
         slot_valid_in     = 1'b1;
         slot_key_in       = flow_i.key;
         slot_length_in    = flow_i.len;
         slot_payload_in   = flow_i.payload;
         slot_last_time_in = flow_i.now;
         slot_average_in   = '0;
      end
   end

   // Slot valid bit and the transaction register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         flow_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         flow_ff       <= flow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_key_ff       <= slot_key_in;
         slot_length_ff    <= slot_length_in;
         slot_payload_ff   <= slot_payload_in;
         slot_last_time_ff <= slot_last_time_in;
         slot_average_ff   <= slot_average_in;
      end
   end

   assign flow_o = flow_ff;

endmodule

// ===== sv/can_frame_change_tracker.sv =====
// ----------------------------------------------------------------------------
// can_frame_change_tracker
// Tracks received CAN frames by interface and identifier and reports
// first sightings, changed payload bytes and the running arrival interval.
// ----------------------------------------------------------------------------
// Each frame walks a chain of TABLE_ENTRIES slot cells, one cell per cycle while
// the chain advances; its response is registered at the output after the last
// cell. The chain is fully pipelined: a new transaction is accepted every cycle,
// and the whole chain holds only while a finished response waits at the output.
// Frames stay in order along the chain, so a frame always sees the table as
// left by every earlier frame. Slots are claimed lowest first and never
// freed; a new key that reaches the end of the chain is reported as dropped.
module can_frame_change_tracker #(
   parameter int TABLE_ENTRIES   = 64,
   parameter int INTERFACE_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cftr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cftr_pkg::rsp_type rsp_data
);

   localparam logic [cftr_pkg::IFACE_BITS-1:0] IFACE_1 =
      cftr_pkg::IFACE_BITS'(1 % INTERFACE_COUNT);
   localparam logic [cftr_pkg::IFACE_BITS-1:0] IFACE_2 =
      cftr_pkg::IFACE_BITS'(2 % INTERFACE_COUNT);
   localparam logic [cftr_pkg::IFACE_BITS-1:0] IFACE_3 =
      cftr_pkg::IFACE_BITS'(3 % INTERFACE_COUNT);

   logic                            advance;
   logic [cftr_pkg::SEQ_BITS-1:0]   seq_ff, seq_in;
   logic [cftr_pkg::IFACE_BITS-1:0] iface;
   logic                            rsp_valid_ff;
   cftr_pkg::rsp_type               rsp_ff, rsp_in;
   cftr_pkg::flow_type              head;
   cftr_pkg::flow_type              chain [TABLE_ENTRIES+1];
   cftr_pkg::flow_type              tail;

   // Whole chain moves unless a response is stuck at the output
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Sequence count, bumped per accepted transaction
   assign seq_in = seq_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (req_valid && advance) begin
         seq_ff <= seq_in;
      end
   end

   // Interface number reduced to the configured interface count
   always_comb begin
      case (req_data.interface_number)
         2'd0:    iface = '0;
         2'd1:    iface = IFACE_1;
         2'd2:    iface = IFACE_2;
         default: iface = IFACE_3;
      endcase
   end

   // Chain head
   always_comb begin
      head.valid   = req_valid;
      head.done    = 1'b0;
      head.first   = 1'b0;
      head.mask    = '0;
      head.average = '0;
      head.seq     = seq_in;
      head.key     = {iface, req_data.frame_id};
      head.len     = req_data.byte_count;
      head.payload = req_data.payload;
      head.now     = req_data.arrival_time;
   end

   assign chain[0] = head;

   // Slot cells
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      cftr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .flow_i  (chain[g]),
         .flow_o  (chain[g+1])
      );
   end

   assign tail = chain[TABLE_ENTRIES];

   // Response formatting
   always_comb begin
      rsp_in.sequence_number = tail.seq;
      rsp_in.first_seen      = tail.first;
      rsp_in.changed_bytes   = tail.mask;
      rsp_in.notify          = tail.first || (tail.mask != '0);
      rsp_in.mean_interval   = tail.average;
      rsp_in.dropped_full    = !tail.done;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
